/* rtl/double_ended_task_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// double_ended_task_queue_top_assert.svh
// Assertion macros used by the task queue datapath, detq_dp. Sampled on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_TASK_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_TASK_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define DETQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("task queue assertion failed");

// Next-cycle implication.
`define DETQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("task queue assertion failed");

`endif

/* rtl/detq_pkg.sv */
// ----------------------------------------------------------------------------
// detq_pkg
// Shared sizes, codes and control types for the double-ended task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package detq_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 2'd0,
    K_PUSH_BACK  = 2'd1,
    K_POP_FRONT  = 2'd2,
    K_POP_BACK   = 2'd3
  } kind_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic exec;  // perform the accepted operation
    logic load;  // move the finished result into the output register
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/detq_ctrl.sv */
// ----------------------------------------------------------------------------
// detq_ctrl
// Sequencer: accept one word, wait in S_HOLD for the store read, hand the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module detq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output detq_pkg::cmd_t     cmd
);
  import detq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.exec      = 1'b0;
    cmd.load      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // load once the output register is empty or draining
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/detq_dp.sv */
// ----------------------------------------------------------------------------
// detq_dp
// Ring buffer datapath: front/back slot indices, entry count, handle store
// with registered read, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module detq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire detq_pkg::cmd_t                cmd,
  input  wire logic [detq_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [detq_pkg::HANDLE_W-1:0] in_task_handle,
  output logic [detq_pkg::HANDLE_W-1:0]      out_popped_handle,
  output logic [detq_pkg::STAT_W-1:0]        out_status,
  output logic [detq_pkg::CNT_W-1:0]         out_entry_count
);
  import detq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [HANDLE_W-1:0] mem [DEPTH];
  logic [HANDLE_W-1:0] rd_data_r;

  logic [IDX_W-1:0] front_r, front_nxt, back_r, back_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic              res_pop_r, res_pop_nxt;
  logic [CNT_W-1:0]  res_cnt_r;

  logic [HANDLE_W-1:0] out_handle_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [IDX_W-1:0] front_prev, front_next, back_prev;
  logic             full, empty;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [IDX_W:0]   ring_sum;
  logic [IDX_W-1:0] ring_end;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);

  assign front_prev = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_next = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign back_prev  = (back_r == '0) ? LAST_IDX : back_r - 1'b1;

  always_comb begin
    front_nxt      = front_r;
    back_nxt       = back_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = ST_OK;
    res_pop_nxt    = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = back_r;
    rd_addr        = front_r;
    case (kind_t'(in_kind))
      K_PUSH_FRONT: begin
        wr_addr = front_prev;
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.exec;
          front_nxt = front_prev;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      K_PUSH_BACK: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en    = cmd.exec;
          back_nxt = (back_r == LAST_IDX) ? '0 : back_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      K_POP_FRONT: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          rd_en       = cmd.exec;
          res_pop_nxt = 1'b1;
          front_nxt   = front_next;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      K_POP_BACK: begin
        rd_addr = back_prev;
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          rd_en       = cmd.exec;
          res_pop_nxt = 1'b1;
          back_nxt    = back_prev;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      default: begin
        res_status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_task_handle;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      cnt_r   <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_pop_r    <= res_pop_nxt;
      res_cnt_r    <= cnt_nxt;
    end
    if (cmd.load) begin
      out_handle_r <= res_pop_r ? rd_data_r : '0;
      out_status_r <= res_status_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  assign out_popped_handle = out_handle_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_cnt_r;

  // back index must sit count slots past the front index
  assign ring_sum = {1'b0, front_r} + cnt_r[IDX_W:0];
  assign ring_end = (ring_sum >= (IDX_W + 1)'(DEPTH)) ?
                    IDX_W'(ring_sum - (IDX_W + 1)'(DEPTH)) : ring_sum[IDX_W-1:0];

`include "double_ended_task_queue_top_assert.svh"

  `DETQ_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= FULL_CNT)
  `DETQ_ASSERT_IMPL(a_ring_consistent, 1'b1, ring_end == back_r)
  `DETQ_ASSERT_NEXT(a_cnt_idle_hold, !cmd.exec, $stable(cnt_r))
  `DETQ_ASSERT_NEXT(a_full_push_drop, cmd.exec && full && !in_kind[1], $stable(cnt_r))
  `DETQ_ASSERT_IMPL(a_no_exec_and_load, cmd.exec, !cmd.load)

endmodule

`default_nettype wire

/* rtl/double_ended_task_queue_top.sv */
// ----------------------------------------------------------------------------
// double_ended_task_queue_top
// Double-ended queue of 16-bit task handles, 64 entries, in a ring buffer.
// Each input word pushes a handle at the front or back, or pops one from the
// front or back, and yields exactly one result word: the popped handle (zero
// unless a pop succeeded), a status (ok, pop on empty, push on full dropped)
// and the entry count after the operation. The accepting edge updates the
// indices and issues the registered store read. The controller then sits in
// S_HOLD until the output register is free; that edge loads the output
// register and raises out_valid. in_ready is low in S_HOLD, so a new word is
// taken only after the last result is loaded. The load waits while the output
// register holds an untaken result, and in_ready stays low until it goes. A
// finished result waits in the output register while the next word is
// accepted. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_task_queue_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [detq_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [detq_pkg::HANDLE_W-1:0] in_task_handle,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [detq_pkg::HANDLE_W-1:0]      out_popped_handle,
  output logic [detq_pkg::STAT_W-1:0]        out_status,
  output logic [detq_pkg::CNT_W-1:0]         out_entry_count
);
  import detq_pkg::*;

  cmd_t cmd;

  detq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  detq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_task_handle    (in_task_handle),
    .out_popped_handle (out_popped_handle),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

endmodule

`default_nettype wire

/* sim/tb_double_ended_task_queue_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_task_queue_top
// Self-checking bench for the double-ended task queue. A short directed run
// covers empty pops, extreme handles and both ends. It is followed by bursts
// of random operations, most weighted toward pushes or pops, that drive
// the queue through full and empty and wrap both indices. Each accepted
// word is run through a ring-buffer predictor. Each reply is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_double_ended_task_queue_top;

  import detq_pkg::*;

  localparam int RANDOM_OPS  = 850;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
  } deque_op_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STAT_W-1:0]   status;
    logic [CNT_W-1:0]    count;
  } deque_reply_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind        = '0;
  logic [HANDLE_W-1:0] in_task_handle = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [HANDLE_W-1:0] out_popped_handle;
  logic [STAT_W-1:0]   out_status;
  logic [CNT_W-1:0]    out_entry_count;

  deque_op_t    op_queue[$];
  deque_reply_t pending_replies[$];
  int           total_ops;
  int           words_in  = 0;
  int           errors    = 0;
  int           cycles    = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  // predictor state
  logic [HANDLE_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]    head_slot = '0;
  logic [IDX_W-1:0]    tail_slot = '0;
  logic [CNT_W-1:0]    fill      = '0;

  double_ended_task_queue_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_task_handle    (in_task_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_popped_handle (out_popped_handle),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic deque_reply_t deque_apply(kind_t op, logic [HANDLE_W-1:0] h);
    deque_reply_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (fill == CNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else if (op == K_PUSH_FRONT) begin
          head_slot = head_slot - 1'b1;
          ring[head_slot] = h;
          fill = fill + 1'b1;
        end else begin
          ring[tail_slot] = h;
          tail_slot = tail_slot + 1'b1;
          fill = fill + 1'b1;
        end
      end
      K_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.handle = ring[head_slot];
          head_slot = head_slot + 1'b1;
          fill = fill - 1'b1;
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_slot = tail_slot - 1'b1;
          r.handle = ring[tail_slot];
          fill = fill - 1'b1;
        end
      end
    endcase
    r.count = fill;
    return r;
  endfunction

  // sender idles lightly while the receiver idles heavily, then the reverse,
  // then neither
  function automatic int idle_pct(bit receiver);
    if (words_in < total_ops / 3) begin
      return receiver ? 79 : 13;
    end else if (words_in < 2 * total_ops / 3) begin
      return receiver ? 13 : 79;
    end
    return 0;
  endfunction

  function automatic deque_op_t make_op(kind_t k, logic [HANDLE_W-1:0] h);
    deque_op_t o;
    o.kind = k;
    o.handle = h;
    return o;
  endfunction

  always @(posedge clk) begin : drive_words
    deque_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= K_PUSH_FRONT;
      in_task_handle <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pending_replies.push_back(deque_apply(kind_t'(in_kind), in_task_handle));
        words_in <= words_in + 1;
      end
      // advance to the next word only when none is held
      if (!in_valid || in_ready) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          op = op_queue.pop_front();
          in_valid <= 1'b1;
          in_kind <= op.kind;
          in_task_handle <= op.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver stall so the block backs up and drops in_ready
  always @(posedge clk) begin : hold_receiver
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= 100) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : check_words
    deque_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply handle %h status %0d count %0d",
                   $time, out_popped_handle, out_status, out_entry_count);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (out_popped_handle !== want.handle) begin
            $display("%0t: popped handle expected %h, actual %h",
                     $time, want.handle, out_popped_handle);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, out_status);
            errors++;
          end
          if (out_entry_count !== want.count) begin
            $display("%0t: entry count expected %0d, actual %0d",
                     $time, want.count, out_entry_count);
            errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int     n;
    int     burst;
    int     push_pct;
    kind_t  k;
    // directed: empty pops, extreme handles, both ends, pop back to empty
    op_queue.push_back(make_op(K_POP_FRONT,  16'h1111));
    op_queue.push_back(make_op(K_POP_BACK,   16'hFFFF));
    op_queue.push_back(make_op(K_PUSH_FRONT, 16'h0000));
    op_queue.push_back(make_op(K_PUSH_BACK,  16'hFFFF));
    op_queue.push_back(make_op(K_PUSH_FRONT, 16'h8001));
    op_queue.push_back(make_op(K_PUSH_BACK,  16'h7FFE));
    op_queue.push_back(make_op(K_POP_BACK,   16'h0000));
    op_queue.push_back(make_op(K_POP_FRONT,  16'hFFFF));
    op_queue.push_back(make_op(K_POP_FRONT,  16'h0000));
    op_queue.push_back(make_op(K_POP_BACK,   16'h0000));
    op_queue.push_back(make_op(K_POP_BACK,   16'h0000));
    op_queue.push_back(make_op(K_POP_FRONT,  16'h0000));
    op_queue.push_back(make_op(K_PUSH_BACK,  16'hA5A5));
    op_queue.push_back(make_op(K_PUSH_BACK,  16'h5A5A));
    op_queue.push_back(make_op(K_PUSH_FRONT, 16'hC3C3));
    op_queue.push_back(make_op(K_POP_FRONT,  16'h0000));
    op_queue.push_back(make_op(K_POP_FRONT,  16'h0000));
    op_queue.push_back(make_op(K_POP_BACK,   16'h0000));
    op_queue.push_back(make_op(K_POP_BACK,   16'h0000));

    // random bursts, most leaning toward pushes or pops so the queue
    // swings between full and empty
    n = 0;
    while (n < RANDOM_OPS) begin
      burst = $urandom_range(80, 8);
      case ($urandom_range(3))
        0: push_pct = 15;
        1: push_pct = 50;
        2: push_pct = 85;
        default: push_pct = 100;
      endcase
      repeat (burst) begin
        if ($urandom_range(99) < push_pct) begin
          k = $urandom_range(1) ? K_PUSH_BACK : K_PUSH_FRONT;
        end else begin
          k = $urandom_range(1) ? K_POP_BACK : K_POP_FRONT;
        end
        op_queue.push_back(make_op(k, HANDLE_W'($urandom)));
        n++;
      end
    end
    total_ops = op_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || in_valid) @(posedge clk);
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
